### hw/rtl/btq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btq_pkg
// Shared types, constants and helpers for the bitmap text quad layout block.
// ----------------------------------------------------------------------------
package btq_pkg;

  localparam int ATLAS_COLUMNS_DEF = 16;
  localparam int COORD_BITS_DEF    = 16;

  localparam int CELL        = 8;
  localparam int LINE_STEP   = 18;
  localparam int GAP         = 2;
  localparam int SPACE_ADV   = 6;
  localparam int LOWER_START = 16;
  localparam int ESC_DIGITS  = 6;

  localparam logic [7:0] CHAR_SPACE   = 8'h20;
  localparam logic [7:0] CHAR_NEWLINE = 8'h0a;
  localparam logic [7:0] CHAR_ESCAPE  = 8'hff;

  localparam logic [15:0] WRAP_WIDTH_DEF = 16'd640;
  localparam logic [7:0]  START_CHAN_DEF = 8'd255;

  localparam logic KIND_BYTE = 1'b0;
  localparam logic KIND_TRIM = 1'b1;

  localparam logic RES_VERTEX  = 1'b0;
  localparam logic RES_SUMMARY = 1'b1;

  typedef enum logic [1:0] {
    CFG_WRAP_WIDTH  = 2'd0,
    CFG_START_RED   = 2'd1,
    CFG_START_GREEN = 2'd2,
    CFG_START_BLUE  = 2'd3
  } cfg_idx_e;

  // One laid-out byte as handed to the result sequencer
  typedef struct packed {
    logic        has_quad;
    logic        has_sum;
    logic [15:0] left;
    logic [15:0] right;
    logic [15:0] upper;
    logic [15:0] lower;
    logic [7:0]  ul;
    logic [7:0]  ur;
    logic [7:0]  vu;
    logic [7:0]  vl;
    logic [23:0] colour;
    logic [15:0] quad_total;
  } btq_res_t;

  // Non-hex characters count as zero
  function automatic logic [3:0] hex_digit(input logic [7:0] b);
    logic [3:0] d;
    d = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      d = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      d = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      d = 4'(b - 8'h37);
    end
    return d;
  endfunction

endpackage

### hw/rtl/btq_trim_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btq_trim_mem
// Glyph trim table: 256 x 8, one write and one registered read per cycle,
// with write-to-read forwarding for a same-edge hit.
// ----------------------------------------------------------------------------
module btq_trim_mem (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       wr_en_i,
  input  logic [7:0] wr_addr_i,
  input  logic [7:0] wr_data_i,
  input  logic [7:0] rd_addr_i,
  output logic [7:0] rd_data_o
);

  logic [7:0] trim_mem [256];
  logic [7:0] rdata_q;
  logic [7:0] fwd_data_q;
  logic       fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      trim_mem[wr_addr_i] <= wr_data_i;
    end
    rdata_q    <= trim_mem[rd_addr_i];
    fwd_data_q <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rdata_q;

endmodule

### hw/rtl/btq_layout.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btq_layout
// Input stage, configuration registers, trim table and layout state.
// Reads the trim entry as the byte is taken, lays it out from the input stage.
// ----------------------------------------------------------------------------
module btq_layout #(
  parameter int ATLAS_COLUMNS = btq_pkg::ATLAS_COLUMNS_DEF,
  parameter int COORD_BITS    = btq_pkg::COORD_BITS_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [1:0]        cfg_index_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic              kind_i,
  input  logic [7:0]        byte_value_i,
  input  logic [3:0]        trim_left_i,
  input  logic [3:0]        trim_right_i,
  input  logic              first_byte_i,
  input  logic              last_byte_i,
  input  logic              emit_free_i,
  output logic              push_o,
  output btq_pkg::btq_res_t push_res_o
);

  localparam int SW = ((COORD_BITS > 16) ? COORD_BITS : 16) + 2;
  localparam logic [SW-1:0] CMAX = {{(SW-COORD_BITS){1'b0}}, {COORD_BITS{1'b1}}};

  function automatic logic [COORD_BITS-1:0] clampc(input logic signed [SW-1:0] v);
    logic [COORD_BITS-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v > $signed(CMAX)) begin
      r = '1;
    end else begin
      r = v[COORD_BITS-1:0];
    end
    return r;
  endfunction

  // configuration
  logic [15:0] wrap_q;
  logic [7:0]  red_q, green_q, blue_q;

  // input stage
  logic       s1_valid_q;
  logic       s1_kind_q;
  logic [7:0] s1_byte_q;
  logic [3:0] s1_tl_q, s1_tr_q;
  logic       s1_first_q, s1_last_q;

  // layout state
  logic [COORD_BITS-1:0] left_q, right_q, upper_q, lower_q;
  logic [COORD_BITS-1:0] left_d, right_d, upper_d, lower_d;
  logic [23:0]           colour_q, colour_d;
  logic [2:0]            esc_q, esc_d;
  logic [23:0]           hex_q, hex_d;
  logic [15:0]           quad_q, quad_d;

  // atlas tables
  logic [9:0] ucell_tab [256];
  logic [7:0] vup_tab   [256];
  logic [7:0] vlo_tab   [256];

  logic       in_fire;
  logic       s1_adv;
  logic       need_emit;
  logic       has_quad;
  logic [7:0] rd_addr;
  logic [7:0] trim;
  logic [3:0] tl, tr;
  logic [9:0] ucell;

  logic [COORD_BITS-1:0] l0, r0, u0, lo0;
  logic [23:0]           col0, hex0;
  logic [2:0]            esc0;
  logic [15:0]           q0;
  logic signed [SW-1:0]  adv, r_s, lo_s, wrap_s;

  for (genvar g = 0; g < 256; g++) begin : g_atlas
    assign ucell_tab[g] = 10'((g % ATLAS_COLUMNS) * btq_pkg::CELL + btq_pkg::CELL);
    assign vup_tab[g]   = 8'((g / ATLAS_COLUMNS) * btq_pkg::CELL);
    assign vlo_tab[g]   = 8'((g / ATLAS_COLUMNS) * btq_pkg::CELL + btq_pkg::CELL);
  end

  assign in_fire = in_valid_i && !in_stall_o;
  // hold the read on the waiting byte so its data stays fresh
  assign rd_addr = in_fire ? byte_value_i : s1_byte_q;

  btq_trim_mem u_trim_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (s1_adv && (s1_kind_q == btq_pkg::KIND_TRIM)),
    .wr_addr_i (s1_byte_q),
    .wr_data_i ({s1_tr_q, s1_tl_q}),
    .rd_addr_i (rd_addr),
    .rd_data_o (trim)
  );

  assign tl    = trim[3:0];
  assign tr    = trim[7:4];
  assign ucell = ucell_tab[s1_byte_q];

  always_comb begin
    l0   = s1_first_q ? '0 : left_q;
    r0   = s1_first_q ? '0 : right_q;
    u0   = s1_first_q ? '0 : upper_q;
    lo0  = s1_first_q ? COORD_BITS'(btq_pkg::LOWER_START) : lower_q;
    col0 = s1_first_q ? {red_q, green_q, blue_q} : colour_q;
    esc0 = s1_first_q ? 3'd0 : esc_q;
    hex0 = s1_first_q ? 24'd0 : hex_q;
    q0   = s1_first_q ? 16'd0 : quad_q;

    adv    = $signed(SW'(2 * btq_pkg::CELL)) - $signed(SW'({tl, 1'b0}))
             - $signed(SW'({tr, 1'b0}));
    r_s    = $signed(SW'(r0));
    lo_s   = $signed(SW'(lo0));
    wrap_s = $signed(SW'(wrap_q));

    left_d   = l0;
    right_d  = r0;
    upper_d  = u0;
    lower_d  = lo0;
    colour_d = col0;
    esc_d    = esc0;
    hex_d    = hex0;
    quad_d   = q0;
    has_quad = 1'b0;

    if (esc0 != 3'd0) begin
      hex_d = {hex0[19:0], btq_pkg::hex_digit(s1_byte_q)};
      esc_d = esc0 - 3'd1;
      if (esc_d == 3'd0) begin
        colour_d = hex_d;
      end
    end else if (s1_byte_q == btq_pkg::CHAR_SPACE) begin
      left_d  = r0;
      right_d = clampc(r_s + $signed(SW'(btq_pkg::SPACE_ADV)));
    end else if (s1_byte_q == btq_pkg::CHAR_NEWLINE) begin
      upper_d = clampc(lo_s + $signed(SW'(1)));
      lower_d = clampc(lo_s + $signed(SW'(btq_pkg::LINE_STEP)));
      left_d  = '0;
      right_d = clampc(adv);
    end else if (s1_byte_q == btq_pkg::CHAR_ESCAPE) begin
      esc_d = 3'(btq_pkg::ESC_DIGITS);
      hex_d = 24'd0;
    end else begin
      has_quad = 1'b1;
      if (r_s + adv > wrap_s) begin
        upper_d = clampc(lo_s + $signed(SW'(1)));
        lower_d = clampc(lo_s + $signed(SW'(btq_pkg::LINE_STEP)));
        left_d  = '0;
        right_d = clampc(adv);
      end else begin
        left_d  = clampc(r_s + $signed(SW'(btq_pkg::GAP)));
        right_d = clampc(r_s + adv + $signed(SW'(btq_pkg::GAP)));
      end
      if (q0 != 16'hffff) begin
        quad_d = q0 + 16'd1;
      end
    end

    if (s1_last_q) begin
      esc_d = 3'd0;
    end
  end

  assign need_emit  = has_quad || s1_last_q;
  assign s1_adv     = s1_valid_q && ((s1_kind_q == btq_pkg::KIND_TRIM) || !need_emit ||
                                     emit_free_i);
  assign in_stall_o = s1_valid_q && !s1_adv;
  assign push_o     = s1_adv && (s1_kind_q == btq_pkg::KIND_BYTE) && need_emit;

  always_comb begin
    push_res_o.has_quad   = has_quad;
    push_res_o.has_sum    = s1_last_q;
    push_res_o.left       = 16'(left_d);
    push_res_o.right      = 16'(right_d);
    push_res_o.upper      = 16'(upper_d);
    push_res_o.lower      = 16'(lower_d);
    push_res_o.ul         = 8'(ucell - 10'(btq_pkg::CELL) + {6'd0, tl});
    push_res_o.ur         = (ucell < {6'd0, tr}) ? 8'd0 : 8'(ucell - {6'd0, tr});
    push_res_o.vu         = vup_tab[s1_byte_q];
    push_res_o.vl         = vlo_tab[s1_byte_q];
    push_res_o.colour     = colour_d;
    push_res_o.quad_total = quad_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wrap_q  <= btq_pkg::WRAP_WIDTH_DEF;
      red_q   <= btq_pkg::START_CHAN_DEF;
      green_q <= btq_pkg::START_CHAN_DEF;
      blue_q  <= btq_pkg::START_CHAN_DEF;
    end else if (cfg_we_i) begin
      unique case (btq_pkg::cfg_idx_e'(cfg_index_i))
        btq_pkg::CFG_WRAP_WIDTH:  wrap_q  <= cfg_wdata_i;
        btq_pkg::CFG_START_RED:   red_q   <= cfg_wdata_i[7:0];
        btq_pkg::CFG_START_GREEN: green_q <= cfg_wdata_i[7:0];
        btq_pkg::CFG_START_BLUE:  blue_q  <= cfg_wdata_i[7:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_fire) begin
      s1_valid_q <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_kind_q  <= kind_i;
      s1_byte_q  <= byte_value_i;
      s1_tl_q    <= trim_left_i;
      s1_tr_q    <= trim_right_i;
      s1_first_q <= first_byte_i;
      s1_last_q  <= last_byte_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q   <= '0;
      right_q  <= '0;
      upper_q  <= '0;
      lower_q  <= COORD_BITS'(btq_pkg::LOWER_START);
      colour_q <= {3{btq_pkg::START_CHAN_DEF}};
      esc_q    <= 3'd0;
      hex_q    <= 24'd0;
      quad_q   <= 16'd0;
    end else if (s1_adv && (s1_kind_q == btq_pkg::KIND_BYTE)) begin
      left_q   <= left_d;
      right_q  <= right_d;
      upper_q  <= upper_d;
      lower_q  <= lower_d;
      colour_q <= colour_d;
      esc_q    <= esc_d;
      hex_q    <= hex_d;
      quad_q   <= quad_d;
    end
  end

  a_esc_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_q <= 3'(btq_pkg::ESC_DIGITS))
    else $error("escape count out of range");

  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q && (s1_kind_q == btq_pkg::KIND_BYTE) && !emit_free_i)
    else $error("input stalled without a blocked byte");

endmodule

### hw/rtl/btq_emit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btq_emit
// Result sequencer: holds one laid-out byte and sends its four vertices (glyphs
// only) and optional summary, one transfer per cycle unless out_stall_i holds it.
// ----------------------------------------------------------------------------
module btq_emit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  btq_pkg::btq_res_t push_res_i,
  output logic              free_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              result_kind_o,
  output logic [15:0]       pos_x_o,
  output logic [15:0]       pos_y_o,
  output logic [7:0]        tex_u_o,
  output logic [7:0]        tex_v_o,
  output logic [7:0]        red_o,
  output logic [7:0]        green_o,
  output logic [7:0]        blue_o,
  output logic [15:0]       quad_total_o,
  output logic              last_o
);

  typedef enum logic [2:0] {
    VTX_LL  = 3'd0,
    VTX_LR  = 3'd1,
    VTX_UR  = 3'd2,
    VTX_UL  = 3'd3,
    VTX_SUM = 3'd4
  } slot_e;

  slot_e             slot_q, slot_next;
  logic              valid_q;
  btq_pkg::btq_res_t res_q;
  logic              fire;
  logic              is_final;

  assign fire     = valid_q && !out_stall_i;
  assign is_final = (slot_q == VTX_SUM) || ((slot_q == VTX_UL) && !res_q.has_sum);
  assign free_o   = !valid_q || (fire && is_final);

  always_comb begin
    unique case (slot_q)
      VTX_LL:  slot_next = VTX_LR;
      VTX_LR:  slot_next = VTX_UR;
      VTX_UR:  slot_next = VTX_UL;
      default: slot_next = VTX_SUM;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      slot_q  <= VTX_LL;
    end else if (push_i) begin
      valid_q <= 1'b1;
      slot_q  <= push_res_i.has_quad ? VTX_LL : VTX_SUM;
    end else if (fire) begin
      if (is_final) begin
        valid_q <= 1'b0;
      end else begin
        slot_q <= slot_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      res_q <= push_res_i;
    end
  end

  assign out_valid_o = valid_q;
  assign red_o       = res_q.colour[23:16];
  assign green_o     = res_q.colour[15:8];
  assign blue_o      = res_q.colour[7:0];
  assign last_o      = is_final;

  always_comb begin
    result_kind_o = btq_pkg::RES_VERTEX;
    quad_total_o  = 16'd0;
    unique case (slot_q)
      VTX_LL: begin
        pos_x_o = res_q.left;
        pos_y_o = res_q.lower;
        tex_u_o = res_q.ul;
        tex_v_o = res_q.vl;
      end
      VTX_LR: begin
        pos_x_o = res_q.right;
        pos_y_o = res_q.lower;
        tex_u_o = res_q.ur;
        tex_v_o = res_q.vl;
      end
      VTX_UR: begin
        pos_x_o = res_q.right;
        pos_y_o = res_q.upper;
        tex_u_o = res_q.ur;
        tex_v_o = res_q.vu;
      end
      VTX_UL: begin
        pos_x_o = res_q.left;
        pos_y_o = res_q.upper;
        tex_u_o = res_q.ul;
        tex_v_o = res_q.vu;
      end
      default: begin
        result_kind_o = btq_pkg::RES_SUMMARY;
        pos_x_o       = res_q.right;
        pos_y_o       = res_q.lower;
        tex_u_o       = 8'd0;
        tex_v_o       = 8'd0;
        quad_total_o  = res_q.quad_total;
      end
    endcase
  end

  a_hold_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(slot_q))
    else $error("result slot moved while stalled");

  a_summary_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == btq_pkg::RES_SUMMARY) |-> last_o)
    else $error("summary not marked last");

  a_vertex_before_sum : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (result_kind_o == btq_pkg::RES_VERTEX) && res_q.has_sum |-> !last_o)
    else $error("vertex marked last ahead of summary");

  a_no_push_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> free_o)
    else $error("byte pushed into busy sequencer");

endmodule

### hw/rtl/bitmap_text_quad_layout.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_text_quad_layout
// Lays out message bytes as textured quads from a trimmed bitmap font atlas.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+----------------------------
//   config   | in        | cfg_we_i             | cfg_index_i, cfg_wdata_i
//   input    | in        | in_valid_i/in_stall_o| kind, byte, trims, first/last
//   result   | out       | out_valid_o/out_stall_i | vertex or size summary
//
// A glyph byte gives four results, five with the summary, one transfer per
// cycle while out_stall_i is low.
// Trim loads never wait; spaces, newlines and escapes wait only when final.
// First result is offered once its byte has passed the input stage (trim table
// read) and the sequencer register, and transfers when out_stall_i is low.
// No clearing pass after reset; the trim table must be loaded before use.
// A glyph or final byte waits in the input stage while the sequencer is busy
// and stalls the input until its results can be handed over.
// ----------------------------------------------------------------------------
module bitmap_text_quad_layout #(
  parameter int ATLAS_COLUMNS = btq_pkg::ATLAS_COLUMNS_DEF,
  parameter int COORD_BITS    = btq_pkg::COORD_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        kind_i,
  input  logic [7:0]  byte_value_i,
  input  logic [3:0]  trim_left_i,
  input  logic [3:0]  trim_right_i,
  input  logic        first_byte_i,
  input  logic        last_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        result_kind_o,
  output logic [15:0] pos_x_o,
  output logic [15:0] pos_y_o,
  output logic [7:0]  tex_u_o,
  output logic [7:0]  tex_v_o,
  output logic [7:0]  red_o,
  output logic [7:0]  green_o,
  output logic [7:0]  blue_o,
  output logic [15:0] quad_total_o,
  output logic        last_o
);

  logic              push;
  logic              emit_free;
  btq_pkg::btq_res_t push_res;

  btq_layout #(
    .ATLAS_COLUMNS (ATLAS_COLUMNS),
    .COORD_BITS    (COORD_BITS)
  ) u_layout (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .byte_value_i (byte_value_i),
    .trim_left_i  (trim_left_i),
    .trim_right_i (trim_right_i),
    .first_byte_i (first_byte_i),
    .last_byte_i  (last_byte_i),
    .emit_free_i  (emit_free),
    .push_o       (push),
    .push_res_o   (push_res)
  );

  btq_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push_i        (push),
    .push_res_i    (push_res),
    .free_o        (emit_free),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .result_kind_o (result_kind_o),
    .pos_x_o       (pos_x_o),
    .pos_y_o       (pos_y_o),
    .tex_u_o       (tex_u_o),
    .tex_v_o       (tex_v_o),
    .red_o         (red_o),
    .green_o       (green_o),
    .blue_o        (blue_o),
    .quad_total_o  (quad_total_o),
    .last_o        (last_o)
  );

endmodule

### tb/sv/bitmap_text_quad_layout_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bitmap_text_quad_layout_tb
// Self-checking bench for the text quad layout block. A scripted opening run
// covers trim loads, glyphs, spaces, newlines, colour escapes (complete and
// cut off) and negative advances. Random messages follow under several
// layout settings.
// Every result transfer is checked against an in-bench layout predictor
// while both channels idle in random bursts until the calm final phase.
// ----------------------------------------------------------------------------
module bitmap_text_quad_layout_tb;
  import btq_pkg::*;

  localparam int STALL_LIMIT  = 2000;
  localparam int SETTLE       = 8;
  localparam int RANDOM_ITEMS = 250;
  localparam int PHASES       = 6;

  typedef struct packed {
    logic        kind;
    logic [15:0] x;
    logic [15:0] y;
    logic [7:0]  u;
    logic [7:0]  v;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [15:0] quads;
    logic        last;
  } quad_res_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  code;
    logic [3:0]  tl;
    logic [3:0]  tr;
    logic        first;
    logic        fin;
    logic        typed;
    logic [15:0] sx;
    logic [15:0] sy;
    logic [23:0] rgb;
    logic [15:0] qt;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [1:0]  cfg_index_i = CFG_WRAP_WIDTH;
  logic [15:0] cfg_wdata_i = 16'd0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        kind_i = KIND_BYTE;
  logic [7:0]  byte_value_i = 8'd0;
  logic [3:0]  trim_left_i = 4'd0;
  logic [3:0]  trim_right_i = 4'd0;
  logic        first_byte_i = 1'b0;
  logic        last_byte_i = 1'b0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        result_kind_o;
  logic [15:0] pos_x_o;
  logic [15:0] pos_y_o;
  logic [7:0]  tex_u_o;
  logic [7:0]  tex_v_o;
  logic [7:0]  red_o;
  logic [7:0]  green_o;
  logic [7:0]  blue_o;
  logic [15:0] quad_total_o;
  logic        last_o;

  bitmap_text_quad_layout i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .kind_i       (kind_i),
    .byte_value_i (byte_value_i),
    .trim_left_i  (trim_left_i),
    .trim_right_i (trim_right_i),
    .first_byte_i (first_byte_i),
    .last_byte_i  (last_byte_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .result_kind_o(result_kind_o),
    .pos_x_o      (pos_x_o),
    .pos_y_o      (pos_y_o),
    .tex_u_o      (tex_u_o),
    .tex_v_o      (tex_v_o),
    .red_o        (red_o),
    .green_o      (green_o),
    .blue_o       (blue_o),
    .quad_total_o (quad_total_o),
    .last_o       (last_o)
  );

  // Layout predictor state
  logic [15:0] wrap_width;
  logic [7:0]  start_r, start_g, start_b;
  logic [3:0]  trim_l [256];
  logic [3:0]  trim_r [256];
  bit          trim_set [256];
  int          lft, rgt, upr, lwr;
  logic [23:0] colour;
  int          esc_left;
  logic [23:0] hex_acc;
  int          quads;

  quad_res_t   due_vertices [$];
  dir_row_t    script [$];
  int          items_sent;
  int          results_seen;
  int          fails;
  bit          calm;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  function automatic int sat16(input int v);
    if (v < 0) return 0;
    if (v > 65535) return 65535;
    return v;
  endfunction

  function automatic logic [7:0] texel(input int v);
    if (v < 0) return 8'd0;
    return 8'(v);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return 4'(c - 8'h30);
    if (c >= 8'h61 && c <= 8'h66) return 4'(c - 8'h61 + 8'd10);
    if (c >= 8'h41 && c <= 8'h46) return 4'(c - 8'h41 + 8'd10);
    return 4'd0;
  endfunction

  function automatic int advance_of(input logic [7:0] code);
    return (CELL - int'(trim_l[code]) - int'(trim_r[code])) * 2;
  endfunction

  function automatic string show(input quad_res_t r);
    return $sformatf("kind=%0d x=%0d y=%0d u=%0d v=%0d rgb=%02h%02h%02h quads=%0d last=%0d",
                     r.kind, r.x, r.y, r.u, r.v, r.red, r.green, r.blue, r.quads, r.last);
  endfunction

  function automatic void open_message();
    lft = 0;
    rgt = 0;
    upr = 0;
    lwr = LOWER_START;
    colour = {start_r, start_g, start_b};
    esc_left = 0;
    hex_acc = 24'd0;
    quads = 0;
  endfunction

  function automatic void new_line();
    upr = sat16(lwr + 1);
    lwr = sat16(lwr + LINE_STEP);
    lft = 0;
  endfunction

  function automatic void emit(input logic kind, input int x, input int y,
                               input logic [7:0] u, input logic [7:0] v);
    quad_res_t r;
    r = '{kind, 16'(x), 16'(y), u, v, colour[23:16], colour[15:8], colour[7:0],
          (kind == RES_SUMMARY) ? 16'(quads) : 16'd0, 1'b0};
    due_vertices.push_back(r);
  endfunction

  // Work out the results of one accepted transfer and queue them
  function automatic void lay_out(input logic kind, input logic [7:0] code,
                                  input logic [3:0] tl, input logic [3:0] tr,
                                  input logic first, input logic fin);
    int adv, col, row, queued;
    logic [7:0] ul, ur, vu, vl;
    quad_res_t tail;
    queued = due_vertices.size();
    if (kind == KIND_TRIM) begin
      trim_l[code] = tl;
      trim_r[code] = tr;
      trim_set[code] = 1'b1;
      return;
    end
    if (first) open_message();
    if (esc_left != 0) begin
      hex_acc = {hex_acc[19:0], hex_val(code)};
      esc_left--;
      if (esc_left == 0) colour = hex_acc;
    end else if (code == CHAR_SPACE) begin
      lft = rgt;
      rgt = sat16(rgt + SPACE_ADV);
    end else if (code == CHAR_NEWLINE) begin
      new_line();
      rgt = sat16(advance_of(CHAR_NEWLINE));
    end else if (code == CHAR_ESCAPE) begin
      esc_left = ESC_DIGITS;
      hex_acc = 24'd0;
    end else begin
      adv = advance_of(code);
      col = int'(code) % ATLAS_COLUMNS_DEF;
      row = int'(code) / ATLAS_COLUMNS_DEF;
      if (rgt + adv > int'(wrap_width)) begin
        new_line();
        rgt = sat16(adv);
      end else begin
        lft = sat16(rgt + GAP);
        rgt = sat16(rgt + adv + GAP);
      end
      ul = texel(col * CELL + int'(trim_l[code]));
      ur = texel(col * CELL + CELL - int'(trim_r[code]));
      vu = texel(row * CELL);
      vl = texel(row * CELL + CELL);
      emit(RES_VERTEX, lft, lwr, ul, vl);
      emit(RES_VERTEX, rgt, lwr, ur, vl);
      emit(RES_VERTEX, rgt, upr, ur, vu);
      emit(RES_VERTEX, lft, upr, ul, vu);
      if (quads < 65535) quads++;
    end
    if (fin) begin
      emit(RES_SUMMARY, rgt, lwr, 8'd0, 8'd0);
      esc_left = 0;
    end
    if (due_vertices.size() > queued) begin
      tail = due_vertices.pop_back();
      tail.last = 1'b1;
      due_vertices.push_back(tail);
    end
  endfunction

  function automatic logic [3:0] random_trim();
    if ($urandom_range(0, 9) == 0) return 4'($urandom_range(0, 15));
    return 4'($urandom_range(0, 3));
  endfunction

  function automatic logic [7:0] escape_digit();
    int r;
    r = $urandom_range(0, 29);
    if (r < 10) return 8'h30 + 8'(r);
    if (r < 16) return 8'h61 + 8'(r - 10);
    if (r < 22) return 8'h41 + 8'(r - 16);
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic dir_row_t load_row(input logic [7:0] code, input logic [3:0] tl,
                                        input logic [3:0] tr, input logic flags);
    return '{KIND_TRIM, code, tl, tr, flags, flags, 1'b0, 16'd0, 16'd0, 24'd0, 16'd0};
  endfunction

  function automatic dir_row_t byte_row(input logic [7:0] code, input logic first,
                                        input logic fin);
    return '{KIND_BYTE, code, 4'd0, 4'd0, first, fin, 1'b0, 16'd0, 16'd0, 24'd0, 16'd0};
  endfunction

  function automatic dir_row_t summary_row(input logic [7:0] code, input logic first,
                                           input logic [15:0] x, input logic [15:0] y,
                                           input logic [23:0] rgb, input logic [15:0] qt);
    return '{KIND_BYTE, code, 4'd0, 4'd0, first, 1'b1, 1'b1, x, y, rgb, qt};
  endfunction

  // Present one transfer, hold it until taken, then predict
  task automatic feed(input logic kind, input logic [7:0] code, input logic [3:0] tl,
                      input logic [3:0] tr, input logic first, input logic fin);
    in_valid_i   <= 1'b1;
    kind_i       <= kind;
    byte_value_i <= code;
    trim_left_i  <= tl;
    trim_right_i <= tr;
    first_byte_i <= first;
    last_byte_i  <= fin;
    do @(posedge clk_i); while (in_stall_o);
    items_sent++;
    lay_out(kind, code, tl, tr, first, fin);
  endtask

  task automatic idle_gap();
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk_i);
    end
  endtask

  // Load the glyph's trims first when none are known yet, now and then reload
  task automatic send_byte(input logic [7:0] code, input logic first, input logic fin);
    if (code != CHAR_SPACE && code != CHAR_ESCAPE &&
        (!trim_set[code] || $urandom_range(0, 19) == 0)) begin
      feed(KIND_TRIM, code, random_trim(), random_trim(),
           1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
      idle_gap();
    end
    feed(KIND_BYTE, code, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)), first, fin);
    idle_gap();
  endtask

  task automatic random_message();
    logic [7:0] msg [$];
    int len, pick, digits;
    bit noisy;
    noisy = ($urandom_range(0, 6) == 0);
    len = $urandom_range(1, 8);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 19);
      if (pick < 11) begin
        msg.push_back(8'($urandom_range(0, 255)));
      end else if (pick < 14) begin
        msg.push_back(CHAR_SPACE);
      end else if (pick < 16) begin
        msg.push_back(CHAR_NEWLINE);
      end else begin
        msg.push_back(CHAR_ESCAPE);
        digits = noisy ? $urandom_range(0, 5) : ESC_DIGITS;
        repeat (digits) msg.push_back(escape_digit());
      end
    end
    for (int i = 0; i < msg.size(); i++) begin
      if (noisy) begin
        send_byte(msg[i], $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
      end else begin
        send_byte(msg[i], i == 0, i == msg.size() - 1);
      end
    end
  endtask

  // Hold off the sender until every result is back and the pipe is quiet
  task automatic drain();
    in_valid_i <= 1'b0;
    while (due_vertices.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_WRAP_WIDTH:  wrap_width = val;
      CFG_START_RED:   start_r = val[7:0];
      CFG_START_GREEN: start_g = val[7:0];
      default:         start_b = val[7:0];
    endcase
  endtask

  task automatic program_layout(input logic [15:0] w, input logic [7:0] r,
                                input logic [7:0] g, input logic [7:0] b);
    write_reg(CFG_WRAP_WIDTH, w);
    write_reg(CFG_START_RED, {8'd0, r});
    write_reg(CFG_START_GREEN, {8'd0, g});
    write_reg(CFG_START_BLUE, {8'd0, b});
    cfg_we_i <= 1'b0;
  endtask

  task automatic log_mismatch(input string what, input quad_res_t want, input quad_res_t seen);
    fails++;
    if (fails <= 10) begin
      $display("%0t: %s", $realtime, what);
      $display("  expected %s", show(want));
      $display("  actual   %s", show(seen));
    end
  endtask

  // Result side: random stall bursts until the calm stretch at the end
  initial begin : out_backpressure
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 9)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    quad_res_t seen, want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      seen = '{result_kind_o, pos_x_o, pos_y_o, tex_u_o, tex_v_o, red_o, green_o, blue_o,
               quad_total_o, last_o};
      results_seen++;
      if (due_vertices.size() == 0) begin
        log_mismatch("result transfer with nothing expected", '0, seen);
      end else begin
        want = due_vertices.pop_front();
        if (seen !== want) log_mismatch("result mismatch", want, seen);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("simulation failed");
    $finish;
  end

  initial begin : stimulus
    logic [15:0] w;
    logic [7:0]  r, g, b;
    int goal;
    bit paused;

    items_sent = 0;
    results_seen = 0;
    fails = 0;
    calm = 1'b0;
    paused = 1'b0;
    wrap_width = WRAP_WIDTH_DEF;
    start_r = START_CHAN_DEF;
    start_g = START_CHAN_DEF;
    start_b = START_CHAN_DEF;
    foreach (trim_set[i]) trim_set[i] = 1'b0;
    open_message();

    // Opening script; summaries that follow straight from the defaults are typed in
    script.push_back(load_row(8'h41, 4'd0, 4'd0, 1'b0));
    script.push_back(load_row(CHAR_NEWLINE, 4'd1, 4'd2, 1'b0));
    script.push_back(load_row(8'h00, 4'd15, 4'd15, 1'b0));
    script.push_back(load_row(8'hfe, 4'd8, 4'd0, 1'b1));
    script.push_back(summary_row(8'h41, 1'b1, 16'd18, 16'd16, 24'hffffff, 16'd1));
    script.push_back(summary_row(CHAR_SPACE, 1'b1, 16'd6, 16'd16, 24'hffffff, 16'd0));
    script.push_back(summary_row(CHAR_NEWLINE, 1'b1, 16'd10, 16'd34, 24'hffffff, 16'd0));
    // advance below zero: right edge pinned at zero
    script.push_back(summary_row(8'h00, 1'b1, 16'd0, 16'd16, 24'hffffff, 16'd1));
    script.push_back(byte_row(8'hfe, 1'b1, 1'b0));
    script.push_back(byte_row(CHAR_ESCAPE, 1'b0, 1'b0));
    script.push_back(byte_row(8'h61, 1'b0, 1'b0));
    script.push_back(byte_row(8'h42, 1'b0, 1'b0));
    script.push_back(byte_row(8'h30, 1'b0, 1'b0));
    script.push_back(byte_row(8'h39, 1'b0, 1'b0));
    script.push_back(byte_row(8'h7a, 1'b0, 1'b0));
    script.push_back(byte_row(8'h46, 1'b0, 1'b0));
    script.push_back(summary_row(8'h41, 1'b0, 16'd20, 16'd16, 24'hab090f, 16'd2));
    // escape cut off by the end of the message; space, escape and newline are digits
    script.push_back(byte_row(CHAR_ESCAPE, 1'b1, 1'b0));
    script.push_back(byte_row(CHAR_SPACE, 1'b0, 1'b0));
    script.push_back(byte_row(CHAR_ESCAPE, 1'b0, 1'b0));
    script.push_back(summary_row(CHAR_NEWLINE, 1'b0, 16'd0, 16'd16, 24'hffffff, 16'd0));
    script.push_back(byte_row(8'h41, 1'b1, 1'b0));
    script.push_back(byte_row(CHAR_ESCAPE, 1'b0, 1'b0));
    script.push_back(byte_row(8'h66, 1'b0, 1'b1));

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (script[i]) begin
      feed(script[i].kind, script[i].code, script[i].tl, script[i].tr,
           script[i].first, script[i].fin);
      if (script[i].typed) begin
        void'(due_vertices.pop_back());
        due_vertices.push_back(quad_res_t'{RES_SUMMARY, script[i].sx, script[i].sy,
                                           8'd0, 8'd0, script[i].rgb[23:16],
                                           script[i].rgb[15:8], script[i].rgb[7:0],
                                           script[i].qt, 1'b1});
      end
      idle_gap();
    end

    for (int p = 0; p < PHASES; p++) begin
      r = 8'($urandom_range(0, 255));
      g = 8'($urandom_range(0, 255));
      b = 8'($urandom_range(0, 255));
      case (p)
        0: begin
          w = 16'd0;
          r = 8'd0;
          g = 8'd0;
          b = 8'd0;
        end
        1: begin
          w = 16'hffff;
          r = 8'hff;
          g = 8'hff;
          b = 8'hff;
        end
        2: w = 16'd60;
        3: w = 16'd150;
        4: w = 16'($urandom_range(20, 400));
        default: begin
          w = 16'd100;
          calm = 1'b1;
        end
      endcase
      drain();
      program_layout(w, r, g, b);
      goal = items_sent + RANDOM_ITEMS / PHASES;
      while (items_sent < goal) begin
        random_message();
        if (p == 2 && !paused && items_sent > goal - 26) begin
          drain();
          paused = 1'b1;
        end
      end
    end

    drain();
    repeat (12) @(posedge clk_i);

    $display("%0d input transfers taken, %0d result transfers checked", items_sent,
             results_seen);
    $display("wrap widths 0 to 65535, cut-off escapes, negative advances, edges held at zero");
    if (fails == 0 && due_vertices.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
